// ----- rtl/fpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point ALU
// Opcodes, status codes and the word carried down the divider cell chain.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_MIN = 4'd12, OP_MAX = 4'd13, OP_TO_INT = 4'd14, OP_FROM_INT = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2
  } status_t;

  // Result word already settled before the chain (non-divide ops).
  typedef struct packed {
    logic                    valid;
    logic                    is_div;
    logic                    neg;       // divide quotient sign
    logic signed [DataW-1:0] result;
    logic                    cmp;
    status_t                 status;
  } fpa_ctl_t;

endpackage

// ----- rtl/fpa_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring-division step
// Shifts in one numerator bit, trial-subtracts the divisor, passes state on.
// ----------------------------------------------------------------------------
module fpa_div_cell #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 33
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  fpa_pkg::fpa_ctl_t          ctl_in,
  input  logic [NumW-1:0]            num_in,
  input  logic [DenW-1:0]            den_in,
  input  logic [DenW-1:0]            rem_in,
  output fpa_pkg::fpa_ctl_t          ctl_out,
  output logic [NumW-1:0]            num_out,
  output logic [DenW-1:0]            den_out,
  output logic [DenW-1:0]            rem_out
);
  import fpa_pkg::*;

  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic [DenW-1:0] rem_next;
  logic [NumW-1:0] num_next;

  always_comb begin
    trial = {rem_in, num_in[NumW-1]};
    diff  = trial - {1'b0, den_in};
    if (!diff[DenW]) begin
      rem_next = diff[DenW-1:0];
      num_next = {num_in[NumW-2:0], 1'b1};
    end else begin
      rem_next = trial[DenW-1:0];
      num_next = {num_in[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.is_div <= ctl_in.is_div;
      ctl_out.neg    <= ctl_in.neg;
      ctl_out.result <= ctl_in.result;
      ctl_out.cmp    <= ctl_in.cmp;
      ctl_out.status <= ctl_in.status;
      num_out        <= num_next;
      den_out        <= den_in;
      rem_out        <= rem_next;
    end
  end

endmodule

// ----- rtl/fixed_point_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu: signed 32-bit fixed-point ALU, FRAC_BITS fraction bits
// Add/sub/mul/div (round half away from zero), compares, inc/dec, min/max,
// to_int and from_int, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
// Pipeline for every op: decode/multiply register, product round register,
//   one divider cell per quotient bit (33 + FRAC_BITS cells), round/saturate
//   output register.
// Throughput: one word per cycle; the whole chain advances unless the output
//   register holds a word and stall is high.
// Reset: clears every valid bit in the chain; no payload is reset.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  op,
  input  logic signed [31:0] a_raw,
  input  logic signed [31:0] b_raw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] result_raw,
  output logic        compare_true,
  output logic [1:0]  status
);
  import fpa_pkg::*;

  // Quotient bits: |a| << FRAC_BITS fits NumW; one extra bit for rounding.
  localparam int unsigned NumW   = DataW + FRAC_BITS + 1;
  localparam int unsigned DenW   = DataW + 1;
  localparam int unsigned Cells  = NumW;

  // Whole pipe moves together; output register drains on !out_stall.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---------------- stage 1: decode, multiply, simple ops ----------------
  logic signed [63:0] prod;
  logic signed [32:0] sum_ab, dif_ab, inc_a, dec_a;
  logic [31:0]        mag_a, mag_b;
  fpa_ctl_t           s1_ctl;
  logic signed [63:0] s1_prod;
  logic               s1_mul;
  logic [NumW-1:0]    s1_num;
  logic [DenW-1:0]    s1_den;
  fpa_ctl_t           ctl_c;
  logic signed [32+FRAC_BITS:0] fi;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v,
                                                output logic ovf);
    if (v[32] != v[31]) begin
      ovf = 1'b1;
      sat33 = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      ovf = 1'b0;
      sat33 = v[31:0];
    end
  endfunction

  logic ovf;

  always_comb begin
    sum_ab = 33'(a_raw) + 33'(b_raw);
    dif_ab = 33'(a_raw) - 33'(b_raw);
    inc_a  = 33'(a_raw) + 33'sd1;
    dec_a  = 33'(a_raw) - 33'sd1;
    mag_a  = a_raw[31] ? 32'(-a_raw) : a_raw;
    mag_b  = b_raw[31] ? 32'(-b_raw) : b_raw;
    fi     = (33+FRAC_BITS)'(a_raw) <<< FRAC_BITS;
    ovf    = 1'b0;
    ctl_c.valid  = in_valid;
    ctl_c.is_div = 1'b0;
    ctl_c.neg    = a_raw[31] ^ b_raw[31];
    ctl_c.result = '0;
    ctl_c.cmp    = 1'b0;
    ctl_c.status = ST_OK;
    case (op_t'(op))
      OP_ADD: ctl_c.result = sat33(sum_ab, ovf);
      OP_SUB: ctl_c.result = sat33(dif_ab, ovf);
      OP_MUL: ctl_c.result = '0;
      OP_DIV: begin
        if (b_raw == 32'sd0) begin
          ctl_c.status = ST_DIV0;
          ctl_c.result = a_raw[31] ? 32'sh8000_0000 :
                         (a_raw != 32'sd0 ? 32'sh7fff_ffff : 32'sd0);
        end else begin
          ctl_c.is_div = 1'b1;
        end
      end
      OP_GT:  ctl_c.cmp = a_raw > b_raw;
      OP_LT:  ctl_c.cmp = a_raw < b_raw;
      OP_GE:  ctl_c.cmp = a_raw >= b_raw;
      OP_LE:  ctl_c.cmp = a_raw <= b_raw;
      OP_EQ:  ctl_c.cmp = a_raw == b_raw;
      OP_NE:  ctl_c.cmp = a_raw != b_raw;
      OP_INC: ctl_c.result = sat33(inc_a, ovf);
      OP_DEC: ctl_c.result = sat33(dec_a, ovf);
      OP_MIN: ctl_c.result = (a_raw < b_raw) ? a_raw : b_raw;
      OP_MAX: ctl_c.result = (a_raw < b_raw) ? b_raw : a_raw;
      OP_TO_INT: ctl_c.result = a_raw >>> FRAC_BITS;
      OP_FROM_INT: begin
        if (fi > (33+FRAC_BITS)'(32'sh7fff_ffff)) begin
          ovf = 1'b1;
          ctl_c.result = 32'sh7fff_ffff;
        end else if (fi < -(33+FRAC_BITS)'(33'sh0_8000_0000)) begin
          ovf = 1'b1;
          ctl_c.result = 32'sh8000_0000;
        end else begin
          ctl_c.result = fi[31:0];
        end
      end
      default: ctl_c.result = '0;
    endcase
    if (ovf) ctl_c.status = ST_OVF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
    end else if (en) begin
      s1_ctl.valid <= ctl_c.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctl.is_div <= ctl_c.is_div;
      s1_ctl.neg    <= ctl_c.neg;
      s1_ctl.result <= ctl_c.result;
      s1_ctl.cmp    <= ctl_c.cmp;
      s1_ctl.status <= ctl_c.status;
      s1_prod <= 64'(a_raw) * 64'(b_raw);
      s1_mul  <= (op_t'(op) == OP_MUL);
      // 2*|a|<<F against |b| yields q*2 + round bit in the last cell.
      s1_num  <= NumW'({mag_a, {FRAC_BITS{1'b0}}, 1'b0});
      s1_den  <= DenW'(mag_b);
    end
  end

  // ---------------- stage 2: round the product ----------------
  logic [63:0]        pmag;
  logic [63:0]        prnd;
  fpa_ctl_t           s2_ctl;
  logic [NumW-1:0]    s2_num;
  logic [DenW-1:0]    s2_den;

  always_comb begin
    prod = s1_prod;
    pmag = prod[63] ? 64'(-prod) : 64'(prod);
    prnd = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl.valid <= 1'b0;
    end else if (en) begin
      s2_ctl.valid <= s1_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl.is_div <= s1_ctl.is_div;
      s2_ctl.neg    <= s1_ctl.neg;
      s2_ctl.cmp    <= s1_ctl.cmp;
      s2_num        <= s1_num;
      s2_den        <= s1_den;
      if (s1_mul) begin
        if (!prod[63] && prnd > 64'h7fff_ffff) begin
          s2_ctl.result <= 32'sh7fff_ffff;
          s2_ctl.status <= ST_OVF;
        end else if (prod[63] && prnd > 64'h8000_0000) begin
          s2_ctl.result <= 32'sh8000_0000;
          s2_ctl.status <= ST_OVF;
        end else begin
          s2_ctl.result <= prod[63] ? 32'(-prnd) : prnd[31:0];
          s2_ctl.status <= ST_OK;
        end
      end else begin
        s2_ctl.result <= s1_ctl.result;
        s2_ctl.status <= s1_ctl.status;
      end
    end
  end

  // ---------------- divider cell chain ----------------
  fpa_ctl_t        c_ctl [Cells+1];
  logic [NumW-1:0] c_num [Cells+1];
  logic [DenW-1:0] c_den [Cells+1];
  logic [DenW-1:0] c_rem [Cells+1];

  assign c_ctl[0] = s2_ctl;
  assign c_num[0] = s2_num;
  assign c_den[0] = s2_den;
  assign c_rem[0] = '0;

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    fpa_div_cell #(.NumW(NumW), .DenW(DenW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(c_ctl[i]), .num_in(c_num[i]), .den_in(c_den[i]),
      .rem_in(c_rem[i]),
      .ctl_out(c_ctl[i+1]), .num_out(c_num[i+1]), .den_out(c_den[i+1]),
      .rem_out(c_rem[i+1])
    );
  end

  // ---------------- output: round quotient, saturate ----------------
  // num now holds floor(2|a|2^F/|b|); round half up = (x+1)>>1.
  logic [NumW:0] qr;
  fpa_ctl_t      tail;

  assign tail = c_ctl[Cells];
  assign qr   = ({1'b0, c_num[Cells]} + (NumW+1)'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      compare_true <= tail.cmp;
      if (tail.is_div) begin
        if (!tail.neg && qr > (NumW+1)'(32'h7fff_ffff)) begin
          result_raw <= 32'sh7fff_ffff;
          status     <= ST_OVF;
        end else if (tail.neg && qr > (NumW+1)'(32'h8000_0000)) begin
          result_raw <= 32'sh8000_0000;
          status     <= ST_OVF;
        end else begin
          result_raw <= tail.neg ? 32'(-qr) : qr[31:0];
          status     <= ST_OK;
        end
      end else begin
        result_raw <= tail.result;
        status     <= tail.status;
      end
    end
  end

endmodule

// ----- tb/fixed_point_alu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_checker: result predictor and scoreboard for the ALU
// Watches both channels, computes the expected word for every accepted
// operation and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module fixed_point_alu_checker #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         op,
  input  logic signed [31:0] a_raw,
  input  logic signed [31:0] b_raw,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] result_raw,
  input  logic               compare_true,
  input  logic [1:0]         status,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);
  import fpa_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic               flag;
    logic [1:0]         code;
  } alu_word_t;

  alu_word_t expected_words[$];

  localparam longint MaxV = 64'sd2147483647;
  localparam longint MinV = -64'sd2147483648;

  function automatic longint clamp32(input longint v, inout logic [1:0] st);
    if (v > MaxV) begin
      st = ST_OVF;
      return MaxV;
    end
    if (v < MinV) begin
      st = ST_OVF;
      return MinV;
    end
    return v;
  endfunction

  function automatic alu_word_t compute_alu(input logic [3:0] opc,
                                            input logic signed [31:0] x,
                                            input logic signed [31:0] y);
    longint a, b, p, r;
    logic [63:0] m, n, d, q;
    logic [1:0] st;
    logic c;
    alu_word_t w;
    a = x;
    b = y;
    r = 0;
    st = ST_OK;
    c = 1'b0;
    case (op_t'(opc))
      OP_ADD: r = clamp32(a + b, st);
      OP_SUB: r = clamp32(a - b, st);
      OP_MUL: begin
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r = clamp32((p < 0) ? -longint'(m) : longint'(m), st);
      end
      OP_DIV: begin
        if (b == 0) begin
          st = ST_DIV0;
          r = (a > 0) ? MaxV : ((a < 0) ? MinV : 0);
        end else begin
          n = ((a < 0) ? -a : a) << FRAC_BITS;
          d = (b < 0) ? -b : b;
          q = (2 * n + d) / (2 * d);
          r = clamp32(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), st);
        end
      end
      OP_GT: c = a > b;
      OP_LT: c = a < b;
      OP_GE: c = a >= b;
      OP_LE: c = a <= b;
      OP_EQ: c = a == b;
      OP_NE: c = a != b;
      OP_INC: r = clamp32(a + 1, st);
      OP_DEC: r = clamp32(a - 1, st);
      OP_MIN: r = (a < b) ? a : b;
      OP_MAX: r = (a < b) ? b : a;
      OP_TO_INT: r = a >>> FRAC_BITS;
      default: r = clamp32(a * (64'sd1 <<< FRAC_BITS), st);
    endcase
    w.value = r[31:0];
    w.flag = c;
    w.code = st;
    return w;
  endfunction

  always @(posedge clk) begin
    alu_word_t exp_w;
    int bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
      expected_words.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_words.push_back(compute_alu(op, a_raw, b_raw));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: result_raw %0d", result_raw);
          bad++;
        end else begin
          exp_w = expected_words.pop_front();
          if (result_raw !== exp_w.value) begin
            $error("result_raw: expected %0d, actual %0d", exp_w.value, result_raw);
            bad++;
          end
          if (compare_true !== exp_w.flag) begin
            $error("compare_true: expected %0b, actual %0b", exp_w.flag, compare_true);
            bad++;
          end
          if (status !== exp_w.code) begin
            $error("status: expected %0d, actual %0d", exp_w.code, status);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

  assign pending = expected_words.size();

endmodule

// ----- tb/fixed_point_alu_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_tb: testbench top for the fixed-point ALU
// Drives directed corner operations then random words with bursty idling
// on both channels; a checker instance predicts and scores every result.
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;
  import fpa_pkg::*;

  localparam int unsigned FracBits = 8;
  localparam int Latency = 36 + FracBits;
  localparam int WatchdogLimit = 4 * Latency + 200;
  localparam int RandomWords = 500;
  localparam int CalmTail = 100;   // final words sent with no idling

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [3:0] op;
  logic signed [31:0] a_raw;
  logic signed [31:0] b_raw;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] result_raw;
  logic compare_true;
  logic [1:0] status;

  int errors;
  int pending;
  int results_seen;
  int words_sent;
  int idle_cycles;
  bit stall_enable;

  fixed_point_alu #(.FRAC_BITS(FracBits)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .a_raw(a_raw), .b_raw(b_raw),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_raw(result_raw), .compare_true(compare_true), .status(status)
  );

  fixed_point_alu_checker #(.FRAC_BITS(FracBits)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .a_raw(a_raw), .b_raw(b_raw),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_raw(result_raw), .compare_true(compare_true), .status(status),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: count cycles where neither channel moves a word.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver stall: random bursts, off in the tail.
  initial begin
    int burst;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_enable && burst == 0 && $urandom_range(0, 5) == 0)
        burst = $urandom_range(1, 3);
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Random operand with bias toward the edges of the 32-bit range.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      3: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 24'($urandom)};
      4: return 32'($urandom_range(0, 4095)) << FracBits;
      default: return $urandom;
    endcase
  endfunction

  // Present one word and hold it until accepted.
  task automatic send_word(input op_t o, input logic [31:0] a, input logic [31:0] b);
    in_valid <= 1'b1;
    op <= o;
    a_raw <= a;
    b_raw <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Optional sender gap, with in_valid dropped.
  task automatic maybe_gap(input bit allow);
    int n;
    if (allow && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    op_t o;
    stall_enable = 1'b1;
    words_sent = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_ADD;
    a_raw <= '0;
    b_raw <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: saturation at both bounds, rounding ties, divide by zero.
    send_word(OP_ADD, 32'h7FFF_FFFF, 32'd1);
    send_word(OP_SUB, 32'h8000_0000, 32'd1);
    send_word(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_MUL, 32'd1, 32'd128);             // tie rounds up
    send_word(OP_MUL, -32'sd1, 32'd128);           // tie rounds away from zero
    send_word(OP_DIV, 32'd5, 32'd0);
    send_word(OP_DIV, -32'sd5, 32'd0);
    send_word(OP_DIV, 32'd0, 32'd0);
    send_word(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_DIV, 32'd1, 32'd512);             // half unit tie
    send_word(OP_GT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_LT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_GE, 32'd7, 32'd7);
    send_word(OP_LE, 32'd7, 32'd7);
    send_word(OP_EQ, 32'd7, 32'd7);
    send_word(OP_NE, 32'd7, 32'd8);
    send_word(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_DEC, 32'h8000_0000, 32'h0);
    send_word(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_TO_INT, -32'sd1, 32'd0);          // floors toward minus infinity
    send_word(OP_FROM_INT, 32'h0080_0000, 32'd0);  // just overflows
    send_word(OP_FROM_INT, 32'hFF80_0000, 32'd0);  // exactly the minimum

    // Random part; every opcode equally likely, last stretch without idling.
    for (int i = 0; i < RandomWords; i++) begin
      if (i == RandomWords - CalmTail) stall_enable = 1'b0;
      maybe_gap(i < RandomWords - CalmTail);
      o = op_t'($urandom_range(0, 15));
      send_word(o, pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);

    $display("Sent %0d words over all 16 opcodes, including saturation, ties and",
             words_sent);
    $display("divide by zero; %0d results were checked.", results_seen);
    if (errors == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
